// ===== sv/atc_pkg.sv =====
// Shared types, character codes and the lexer transition function of the token classifier.
package atc_pkg;

  localparam int CharW     = 8;
  localparam int KindW     = 4;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChQuote  = 8'h22;
  localparam logic [CharW-1:0] ChHash   = 8'h23;
  localparam logic [CharW-1:0] ChDollar = 8'h24;
  localparam logic [CharW-1:0] ChLParen = 8'h28;
  localparam logic [CharW-1:0] ChRParen = 8'h29;
  localparam logic [CharW-1:0] ChComma  = 8'h2C;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChDot    = 8'h2E;
  localparam logic [CharW-1:0] ChColon  = 8'h3A;
  localparam logic [CharW-1:0] ChBslash = 8'h5C;
  localparam logic [CharW-1:0] ChUscore = 8'h5F;
  localparam logic [CharW-1:0] ChLowX   = 8'h78;

  typedef enum logic [3:0] {
    StStart = 4'd0,
    StReg   = 4'd1,
    StDir   = 4'd2,
    StCom   = 4'd3,
    StOne   = 4'd4,
    StMinus = 4'd5,
    StDec   = 4'd6,
    StHex   = 4'd7,
    StSym   = 4'd8,
    StStr   = 4'd9,
    StEsc   = 4'd10
  } lex_state_e;

  typedef enum logic [KindW-1:0] {
    KReg    = 4'd0,
    KDir    = 4'd1,
    KCom    = 4'd2,
    KDec    = 4'd3,
    KHex    = 4'd4,
    KSym    = 4'd5,
    KStr    = 4'd6,
    KNl     = 4'd7,
    KColon  = 4'd8,
    KComma  = 4'd9,
    KLParen = 4'd10,
    KRParen = 4'd11,
    KErr    = 4'd12
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic        incl;
    logic        last;
  } result_t;

  // Results produced by one character: count (0..2) and the two slots.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic        done;
    lex_state_e  next;
    token_kind_e kind;
    logic        incl;
  } step_t;

  function automatic logic is_blank(logic [CharW-1:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_digit(logic [CharW-1:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [CharW-1:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_hex(logic [CharW-1:0] c);
    return is_digit(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic num_end(logic [CharW-1:0] c);
    return is_blank(c) || (c inside {ChLParen, ChComma, ChHash, ChNul});
  endfunction

  // Unused state codes behave as start.
  function automatic logic is_start(lex_state_e st);
    return (st == StStart) || (st > StEsc);
  endfunction

  // One transition; done means a token completes and the lexer returns to start.
  function automatic step_t lex_advance(lex_state_e st, logic [CharW-1:0] c);
    step_t s;
    s.done = 1'b1;
    s.next = StStart;
    s.kind = KErr;
    s.incl = 1'b1;
    case (st)
      StReg: begin
        if (is_blank(c) || c == ChNul) begin
          s.kind = KReg; s.incl = 1'b0;
        end else begin
          s.done = 1'b0; s.next = StReg;
        end
      end
      StDir: begin
        if (is_blank(c) || c == ChNul) begin
          s.kind = KDir; s.incl = 1'b0;
        end else begin
          s.done = 1'b0; s.next = StDir;
        end
      end
      StCom: begin
        if (c == ChNul) begin
          s.kind = KCom; s.incl = 1'b0;
        end else begin
          s.done = 1'b0; s.next = StCom;
        end
      end
      StOne: begin
        if (is_digit(c)) begin
          s.done = 1'b0; s.next = StDec;
        end else if (c == ChLowX) begin
          s.done = 1'b0; s.next = StHex;
        end else if (is_blank(c) || c == ChNul) begin
          s.kind = KDec; s.incl = 1'b0;
        end
      end
      StMinus: begin
        if (is_blank(c)) begin
          s.done = 1'b0; s.next = StMinus;
        end else if (is_digit(c)) begin
          s.done = 1'b0; s.next = StOne;
        end
      end
      StDec: begin
        if (is_digit(c)) begin
          s.done = 1'b0; s.next = StDec;
        end else if (num_end(c)) begin
          s.kind = KDec; s.incl = 1'b0;
        end
      end
      StHex: begin
        if (is_hex(c)) begin
          s.done = 1'b0; s.next = StHex;
        end else if (num_end(c)) begin
          s.kind = KHex; s.incl = 1'b0;
        end
      end
      StSym: begin
        if (is_alpha(c) || is_digit(c) || c == ChUscore) begin
          s.done = 1'b0; s.next = StSym;
        end else if (is_blank(c) ||
                     (c inside {ChNul, ChDot, ChColon, ChRParen, ChComma})) begin
          s.kind = KSym; s.incl = 1'b0;
        end
      end
      StStr: begin
        if (c == ChBslash) begin
          s.done = 1'b0; s.next = StEsc;
        end else if (c != ChNul && c != ChQuote) begin
          s.done = 1'b0; s.next = StStr;
        end else begin
          s.kind = KStr;
        end
      end
      StEsc: begin
        if (c != ChNul) begin
          s.done = 1'b0; s.next = StStr;
        end
      end
      default: begin
        case (c)
          ChHash:   begin s.done = 1'b0; s.next = StCom;   end
          ChDot:    begin s.done = 1'b0; s.next = StDir;   end
          ChQuote:  begin s.done = 1'b0; s.next = StStr;   end
          ChMinus:  begin s.done = 1'b0; s.next = StMinus; end
          ChDollar: begin s.done = 1'b0; s.next = StReg;   end
          ChLParen: s.kind = KLParen;
          ChRParen: s.kind = KRParen;
          ChColon:  s.kind = KColon;
          ChComma:  s.kind = KComma;
          ChNul:    begin s.kind = KNl; s.incl = 1'b0; end
          default: begin
            if (is_digit(c)) begin
              s.done = 1'b0; s.next = StOne;
            end else if (is_alpha(c) || c == ChUscore) begin
              s.done = 1'b0; s.next = StSym;
            end
          end
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

// ===== sv/atc_char_if.sv =====
// Character channel: valid/ready handshake carrying one source byte.
interface atc_char_if;
  logic                       valid;
  logic                       ready;
  logic [atc_pkg::CharW-1:0]  character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

// ===== sv/atc_token_if.sv =====
// Token channel: valid/ready handshake carrying one classification result.
interface atc_token_if;
  logic                       valid;
  logic                       ready;
  logic [atc_pkg::KindW-1:0]  token_kind;
  logic                       char_included;
  logic                       last_result;

  modport source (output valid, output token_kind, output char_included,
                  output last_result, input ready);
  modport sink   (input valid, input token_kind, input char_included,
                  input last_result, output ready);
endinterface

// ===== sv/atc_in_stage.sv =====
// Input register stage: holds one accepted character until the lexer takes it.
module atc_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  atc_char_if.sink                  chr_i,
  input  logic                      take_i,
  output logic                      s1_valid_o,
  output logic [atc_pkg::CharW-1:0] s1_char_o
);
  import atc_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             accept;

  assign chr_i.ready = !valid_q || take_i;
  assign accept      = chr_i.valid && chr_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= chr_i.character;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_char_o  = char_q;
endmodule

// ===== sv/atc_lex.sv =====
// Lexer state register and the per-character step producing zero to two results.
module atc_lex (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s1_valid_i,
  input  logic [atc_pkg::CharW-1:0]    s1_char_i,
  input  logic [atc_pkg::FifoCntW-1:0] fifo_free_i,
  output logic                         take_o,
  output atc_pkg::push_t               push_o
);
  import atc_pkg::*;

  lex_state_e state_q, state_d, next_st;
  step_t      a, b;
  logic       st_start, blank;
  logic [1:0] cnt;
  result_t    r0, r1;

  always_comb begin
    st_start = is_start(state_q);
    blank    = is_blank(s1_char_i);
    a        = lex_advance(state_q, s1_char_i);
    b        = lex_advance(StStart, s1_char_i);
    next_st  = state_q;
    cnt      = 2'd0;
    r0       = '{kind: a.kind, incl: a.incl, last: 1'b1};
    r1       = '{kind: b.kind, incl: b.incl, last: 1'b1};
    if (st_start && blank) begin
      next_st = state_q;
    end else if (!a.done) begin
      next_st = a.next;
    end else begin
      next_st = StStart;
      cnt     = 2'd1;
      // An excluded ending byte is lexed again from start.
      if (!a.incl && !st_start && !blank) begin
        if (b.done) begin
          r0.last = 1'b0;
          cnt     = 2'd2;
        end else begin
          next_st = b.next;
        end
      end
    end
  end

  assign take_o  = s1_valid_i && (FifoCntW'(cnt) <= fifo_free_i);
  assign state_d = take_o ? next_st : state_q;

  always_comb begin
    push_o.cnt = take_o ? cnt : 2'd0;
    push_o.r0  = r0;
    push_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StStart;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== sv/atc_res_fifo.sv =====
// Result queue: takes up to two results per cycle, presents one per transaction.
module atc_res_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  atc_pkg::push_t               push_i,
  output logic [atc_pkg::FifoCntW-1:0] free_o,
  atc_token_if.source                  tok_o
);
  import atc_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;
  result_t             head;

  assign pop    = tok_o.valid && tok_o.ready;
  assign wr_nxt = wr_ptr_q + FifoPtrW'(1);
  assign free_o = FifoCntW'(FifoDepth) - cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
    cnt_d    = cnt_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

  assign head                = mem_q[rd_ptr_q];
  assign tok_o.valid         = (cnt_q != '0);
  assign tok_o.token_kind    = head.kind;
  assign tok_o.char_included = head.incl;
  assign tok_o.last_result   = head.last;
endmodule

// ===== sv/assembly_token_classifier_unit.sv =====
// Top level of the assembly token classifier: input stage, lexer and result queue.
//
// Usage:
//   chr_i carries one byte of an assembly source line per transaction; a zero
//   byte marks end of line. tok_o carries one result per transaction: the
//   token kind, whether the byte that ended the token belongs to it, and a
//   flag on the last result caused by that byte. A byte may cause none, one
//   or two results (two when a token ends on a byte that then forms a
//   token of its own).
//   Path: an accepted byte is held in the input register, classified there by
//   the lexer, and its results are written into the queue, whose head is
//   offered on tok_o.
//   Throughput: one byte per cycle while the output drains one result per
//   cycle. Bytes causing two results add one result each to the four-entry
//   queue; the input stalls only when the queue cannot take the results of
//   the byte held in the input register.
//   Reset: the lexer returns to the start state with no token open, the input
//   register and the result queue empty. No clearing pass is needed.
//   Stall: while tok_o is not ready, hold the head result; the queue fills and
//   then chr_i.ready drops, so no transaction is lost.
module assembly_token_classifier_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  atc_char_if.sink     chr_i,
  atc_token_if.source  tok_o
);
  import atc_pkg::*;

  logic                s1_valid;
  logic [CharW-1:0]    s1_char;
  logic                take;
  logic [FifoCntW-1:0] fifo_free;
  push_t               push;

  // Register the incoming byte; advance when the lexer takes it.
  atc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .chr_i      (chr_i),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_char_o  (s1_char)
  );

  // Classify the held byte; only take it when the queue has room for all its results.
  atc_lex u_lex (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_char_i   (s1_char),
    .fifo_free_i (fifo_free),
    .take_o      (take),
    .push_o      (push)
  );

  // Queue results and present them one transaction at a time.
  atc_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .free_o (fifo_free),
    .tok_o  (tok_o)
  );
endmodule

// ===== sv/atc_checker.sv =====
// Port-level checks on the token classifier's output channel, bound to the top level.
module atc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [atc_pkg::KindW-1:0]   token_kind_i,
  input logic                        char_included_i,
  input logic                        last_result_i
);
  import atc_pkg::*;

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled result dropped");

  // A newline never carries its byte and is always the last result of that byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i == KNl |-> !char_included_i && last_result_i)
    else $error("newline result malformed");

  // The first of a pair ends on an excluded byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_result_i |-> !char_included_i)
    else $error("first of a pair includes its byte");

  // An error token always consumes its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i == KErr |-> char_included_i && last_result_i)
    else $error("error result malformed");

  // No kind beyond error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> token_kind_i <= KErr)
    else $error("token kind out of range");
endmodule

bind assembly_token_classifier_unit atc_checker u_atc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (tok_o.valid),
  .out_ready_i     (tok_o.ready),
  .token_kind_i    (tok_o.token_kind),
  .char_included_i (tok_o.char_included),
  .last_result_i   (tok_o.last_result)
);

// ===== verif/tb_assembly_token_classifier_unit.sv =====
// Testbench for the assembly token classifier: directed, back-pressure and random source lines.
`timescale 1ns / 100ps

module tb_assembly_token_classifier_unit;
  import atc_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and the two channels
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  atc_char_if  chr_if ();
  atc_token_if tok_if ();

  assembly_token_classifier_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .chr_i  (chr_if),
    .tok_o  (tok_if)
  );

  // 8 ns period; low first so that reset is applied before the first edge.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Shared state of the bench
  // ---------------------------------------------------------------------------
  // One step of the lexer as the bench understands it.
  typedef struct {
    bit          done;
    lex_state_e  nxt;
    token_kind_e kind;
    bit          incl;
  } lex_move_t;

  lex_state_e  lex_now = StStart;   // lexer state mirrored by the bench
  result_t     pending_tokens[$];   // tokens still owed by the block, oldest first
  logic [7:0]  line_buf[$];         // source line under construction

  bit          src_gaps;            // sender inserts idle bursts
  bit          sink_gaps;           // receiver inserts stall bursts
  int unsigned hold_off_len = 0;    // request for one long receiver stall

  int          error_count = 0;
  int          items_sent = 0;
  int          directed_items = 0;
  int          tokens_checked = 0;
  int          double_chars = 0;
  int          stall_cycles = 0;
  int          kind_seen[16];

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit blank_ch(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Fold case with bit 5; only the two letter ranges land in a..z.
  function automatic bit alpha_ch(logic [7:0] c);
    return ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
  endfunction

  function automatic bit hex_ch(logic [7:0] c);
    return digit_ch(c) || (((c | 8'h20) >= "a") && ((c | 8'h20) <= "f"));
  endfunction

  function automatic bit word_ch(logic [7:0] c);
    return alpha_ch(c) || digit_ch(c) || (c == ChUscore);
  endfunction

  // ---------------------------------------------------------------------------
  // Lexer mirror
  // ---------------------------------------------------------------------------
  // From start: either a one-byte token, the opening of a longer one, or an error.
  function automatic lex_move_t start_move(logic [7:0] c);
    lex_move_t m;
    m.done = 1'b1;
    m.nxt  = StStart;
    m.kind = KErr;
    m.incl = 1'b1;
    if (c == ChNul) begin
      // The newline token never owns its zero byte.
      m.kind = KNl;
      m.incl = 1'b0;
    end else if (c == ChLParen) begin
      m.kind = KLParen;
    end else if (c == ChRParen) begin
      m.kind = KRParen;
    end else if (c == ChColon) begin
      m.kind = KColon;
    end else if (c == ChComma) begin
      m.kind = KComma;
    end else begin
      m.done = 1'b0;
      if (c == ChHash) m.nxt = StCom;
      else if (c == ChDot) m.nxt = StDir;
      else if (c == ChQuote) m.nxt = StStr;
      else if (c == ChMinus) m.nxt = StMinus;
      else if (c == ChDollar) m.nxt = StReg;
      else if (digit_ch(c)) m.nxt = StOne;
      else if (word_ch(c)) m.nxt = StSym;
      else m.done = 1'b1;  // fits no rule: error token
    end
    return m;
  endfunction

  // One transition from any state. A completed token always returns to start.
  function automatic lex_move_t lex_move(lex_state_e st, logic [7:0] c);
    lex_move_t m;
    bit        word_end;
    m.done   = 1'b1;
    m.nxt    = StStart;
    m.kind   = KErr;
    m.incl   = 1'b1;
    word_end = blank_ch(c) || (c == ChNul);
    case (st)
      StReg, StDir: begin
        if (word_end) begin
          m.kind = (st == StReg) ? KReg : KDir;
          m.incl = 1'b0;
        end else begin
          m.done = 1'b0;
          m.nxt  = st;
        end
      end
      StCom: begin
        if (c == ChNul) begin
          m.kind = KCom;
          m.incl = 1'b0;
        end else begin
          m.done = 1'b0;
          m.nxt  = StCom;
        end
      end
      StOne: begin
        // A single digit may only grow, turn hex, or end on a blank or zero.
        if (digit_ch(c)) begin
          m.done = 1'b0;
          m.nxt  = StDec;
        end else if (c == ChLowX) begin
          m.done = 1'b0;
          m.nxt  = StHex;
        end else if (word_end) begin
          m.kind = KDec;
          m.incl = 1'b0;
        end
      end
      StMinus: begin
        if (blank_ch(c)) begin
          m.done = 1'b0;
          m.nxt  = StMinus;
        end else if (digit_ch(c)) begin
          m.done = 1'b0;
          m.nxt  = StOne;
        end
      end
      StDec, StHex: begin
        if ((st == StDec) ? digit_ch(c) : hex_ch(c)) begin
          m.done = 1'b0;
          m.nxt  = st;
        end else if (word_end || c == ChLParen || c == ChComma || c == ChHash) begin
          m.kind = (st == StDec) ? KDec : KHex;
          m.incl = 1'b0;
        end
      end
      StSym: begin
        if (word_ch(c)) begin
          m.done = 1'b0;
          m.nxt  = StSym;
        end else if (word_end || c == ChDot || c == ChColon || c == ChRParen ||
                     c == ChComma) begin
          m.kind = KSym;
          m.incl = 1'b0;
        end
      end
      StStr: begin
        // Closing quote or end of line both belong to the string.
        if (c == ChBslash) begin
          m.done = 1'b0;
          m.nxt  = StEsc;
        end else if (c != ChNul && c != ChQuote) begin
          m.done = 1'b0;
          m.nxt  = StStr;
        end else begin
          m.kind = KStr;
        end
      end
      StEsc: begin
        // Any byte but zero is escaped; zero here is an error.
        if (c != ChNul) begin
          m.done = 1'b0;
          m.nxt  = StStr;
        end
      end
      default: m = start_move(c);
    endcase
    return m;
  endfunction

  // Advance the mirror by one accepted byte and queue the tokens it owes.
  function automatic void classify_char(logic [7:0] c);
    lex_move_t first;
    lex_move_t second;
    bit        was_idle;
    was_idle = (lex_now == StStart) || (lex_now > StEsc);
    if (was_idle && blank_ch(c)) return;  // skip blanks between tokens
    first   = lex_move(lex_now, c);
    lex_now = first.nxt;
    if (!first.done) return;
    // A byte that ended an open token without belonging to it is lexed again.
    if (!first.incl && !was_idle && !blank_ch(c)) begin
      second = start_move(c);
      if (second.done) begin
        pending_tokens.push_back(result_t'{first.kind, 1'b0, 1'b0});
        pending_tokens.push_back(result_t'{second.kind, second.incl, 1'b1});
        double_chars++;
        return;
      end
      lex_now = second.nxt;
    end
    pending_tokens.push_back(result_t'{first.kind, first.incl, 1'b1});
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Sample both channels at the rising edge; register each input transaction
  // with the mirror and compare each output transaction with the oldest token.
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (chr_if.valid && chr_if.ready) classify_char(chr_if.character);
      if (tok_if.valid && tok_if.ready) begin
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("token kind %0d arrived with none owed",
                                    tok_if.token_kind));
        end else begin
          want = pending_tokens.pop_front();
          if (tok_if.token_kind !== want.kind)
            report_mismatch($sformatf("token %0d token_kind: got %0d, want %0d",
                                      tokens_checked, tok_if.token_kind, want.kind));
          if (tok_if.char_included !== want.incl)
            report_mismatch($sformatf("token %0d char_included: got %b, want %b",
                                      tokens_checked, tok_if.char_included, want.incl));
          if (tok_if.last_result !== want.last)
            report_mismatch($sformatf("token %0d last_result: got %b, want %b",
                                      tokens_checked, tok_if.last_result, want.last));
          kind_seen[want.kind]++;
          tokens_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drive ready at the falling edge. A long hold-off request takes
  // priority over the random stall bursts and is counted here in cycles.
  // ---------------------------------------------------------------------------
  initial begin : token_sink
    int unsigned held;
    tok_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        tok_if.ready <= 1'b0;
        for (held = 1; held < hold_off_len; held++) @(negedge clk_i);
        stall_cycles += hold_off_len;
        hold_off_len = 0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        // Stall burst: ready held low at random.
        tok_if.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
      end else begin
        tok_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one byte per transaction, changed at the falling edge and held
  // until the block takes it. Valid stays high from one byte to the next
  // unless an idle burst is inserted.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      chr_if.valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    chr_if.valid     <= 1'b1;
    chr_if.character <= c;
    do @(posedge clk_i); while (!chr_if.ready);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_alpha();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(0, 11);
    if (r < 7) return pick_alpha();
    if (r < 11) return pick_digit();
    return ChUscore;
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] pick_num_end();
    case ($urandom_range(0, 2))
      0:       return ChComma;
      1:       return ChLParen;
      default: return pick_blank();
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b);
    line_buf.push_back(b);
  endtask

  // Build one source line: mostly well-formed tokens with random content,
  // with some noise bytes and broken tokens mixed in. End with a zero byte.
  task automatic build_line();
    int  ntok;
    int  t;
    bit  line_done;
    logic [7:0] b;
    line_buf.delete();
    ntok      = $urandom_range(1, 6);
    line_done = 1'b0;
    for (t = 0; t < ntok && !line_done; t++) begin
      repeat ($urandom_range(0, 2)) put_byte(pick_blank());
      case ($urandom_range(0, 11))
        0: begin  // register
          put_byte(ChDollar);
          repeat ($urandom_range(1, 3)) put_byte(pick_word_char());
          put_byte(pick_blank());
        end
        1: begin  // directive
          put_byte(ChDot);
          repeat ($urandom_range(1, 4)) put_byte(pick_alpha());
          put_byte(pick_blank());
        end
        2, 3: begin  // symbol, closed by a blank, ':', ',', ')' or '.'
          put_byte(($urandom_range(0, 7) == 0) ? ChUscore : pick_alpha());
          repeat ($urandom_range(0, 4)) put_byte(pick_word_char());
          case ($urandom_range(0, 4))
            0:       put_byte(ChColon);
            1:       put_byte(ChComma);
            2:       put_byte(ChRParen);
            3:       put_byte(ChDot);
            default: put_byte(pick_blank());
          endcase
        end
        4: begin  // longer decimal, sometimes negative
          if ($urandom_range(0, 2) == 0) begin
            put_byte(ChMinus);
            repeat ($urandom_range(0, 1)) put_byte(pick_blank());
          end
          repeat ($urandom_range(2, 4)) put_byte(pick_digit());
          put_byte(pick_num_end());
        end
        5: begin  // one-digit decimal
          if ($urandom_range(0, 2) == 0) put_byte(ChMinus);
          put_byte(pick_digit());
          put_byte(pick_blank());
        end
        6: begin  // hex
          put_byte(pick_digit());
          put_byte(ChLowX);
          repeat ($urandom_range(1, 4)) put_byte(pick_hex());
          put_byte(pick_num_end());
        end
        7: begin  // string with escapes and arbitrary bytes
          put_byte(ChQuote);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
              0: begin
                put_byte(ChBslash);
                put_byte(8'($urandom_range(1, 255)));
              end
              1: begin
                b = 8'($urandom_range(1, 255));
                put_byte((b == ChQuote || b == ChBslash) ? ChUscore : b);
              end
              default: put_byte(pick_word_char());
            endcase
          end
          put_byte(ChQuote);
        end
        8: begin  // punctuation
          case ($urandom_range(0, 3))
            0:       put_byte(ChLParen);
            1:       put_byte(ChRParen);
            2:       put_byte(ChColon);
            default: put_byte(ChComma);
          endcase
        end
        9: begin  // comment runs to end of line
          put_byte(ChHash);
          repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(1, 255)));
          line_done = 1'b1;
        end
        10: put_byte(8'($urandom_range(0, 255)));  // noise
        default: begin  // broken token
          case ($urandom_range(0, 3))
            0: begin
              put_byte(ChQuote);
              put_byte(ChBslash);
              put_byte(ChNul);
            end
            1: begin
              put_byte(ChMinus);
              put_byte(($urandom_range(0, 1)) ? ChNul : pick_alpha());
            end
            2: begin
              put_byte(pick_digit());
              put_byte(8'($urandom_range(33, 255)));
            end
            default: begin
              put_byte(pick_word_char());
              put_byte(8'($urandom_range(0, 255)));
            end
          endcase
        end
      endcase
    end
    put_byte(ChNul);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Extremes of the byte, every token kind and the corner cases of the lexer.
  task automatic test_directed();
    logic [7:0] seq[$];
    seq = '{ChNul,                                   // empty line: newline only
            ChDollar, ChNul,                         // register closed by end of line
            ChDot, ChSpace,                          // directive closed by a blank
            ChHash, 8'hFF, ChNul,                    // comment holding an all-ones byte
            "9", ChTab,                              // one-digit decimal
            ChMinus, ChSpace, "4", "2", ChLParen,    // negative decimal, then '('
            "5", ChLowX, "F", ChComma,               // hex, then ','
            ChUscore, ChColon,                       // symbol, then ':'
            ChQuote, ChBslash, ChNul,                // end of line inside an escape
            ChQuote, 8'h80, ChQuote,                 // string holding a high byte
            ChRParen,
            "7", "q",                                // stray letter after one digit
            8'h80};                                  // high byte from start
    foreach (seq[i]) send_char(seq[i]);
  endtask

  // Hold the receiver off while symbol-colon pairs, two tokens each, keep
  // coming: the result queue fills and the input must stall, not drop.
  task automatic test_output_stall();
    int k;
    src_gaps     = 1'b0;
    hold_off_len = 48;
    for (k = 0; k < 10; k++) begin
      send_char(pick_alpha());
      send_char(ChColon);
    end
    send_char(ChNul);
    src_gaps = 1'b1;
  endtask

  task automatic test_random_lines(input int target);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      build_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    int waited;
    int kinds_hit;
    rst_ni           = 1'b0;
    chr_if.valid     = 1'b0;
    chr_if.character = ChNul;
    src_gaps         = 1'b1;
    sink_gaps        = 1'b1;
    foreach (kind_seen[k]) kind_seen[k] = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    directed_items = items_sent;
    test_output_stall();
    test_random_lines(1000);

    // Last stretch at full rate on both sides.
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random_lines(300);

    @(negedge clk_i);
    chr_if.valid <= 1'b0;

    // Drain the owed tokens, then keep watching for anything stray.
    waited = 0;
    while (pending_tokens.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_tokens.size() != 0)
      report_mismatch($sformatf("%0d owed tokens never arrived", pending_tokens.size()));

    kinds_hit = 0;
    foreach (kind_seen[k]) if (kind_seen[k] != 0) kinds_hit++;
    $display("Run summary: %0d bytes (%0d directed), %0d tokens, %0d bytes with two tokens",
             items_sent, directed_items, tokens_checked, double_chars);
    $display("Run summary: %0d of 13 kinds seen, %0d cycles of output hold-off, %0d mismatches",
             kinds_hit, stall_cycles, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
